// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same form with no reset gating.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cddr_pkg.sv =====
// ----------------------------------------------------------------------------
// cddr_pkg
// Types, constants and helper functions of the dirty-cell display refresh unit.
// ----------------------------------------------------------------------------
package cddr_pkg;

  localparam int COLUMNS   = 16;
  localparam int ROWS      = 2;
  localparam int NUM_CELLS = ROWS * COLUMNS;
  localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SCOL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] ZERO_CODE  = 8'h30;
  localparam logic [7:0] ROW_OFFSET = 8'h40;
  localparam logic [7:0] CURSOR_CMD = 8'h80;

  // Number conversion
  localparam int BIN_W      = 16;
  localparam int BCD_DIGITS = 5;
  localparam int BITCNT_W   = $clog2(BIN_W);
  localparam logic [2:0] MIN_DIGITS = 3'd2;
  localparam logic [2:0] MAX_DIGITS = 3'd5;

  // Function codes of a request
  localparam logic [1:0] FUNC_WRITE_CHAR = 2'd0;
  localparam logic [1:0] FUNC_WRITE_NUM  = 2'd1;
  localparam logic [1:0] FUNC_REFRESH    = 2'd2;

  // Queue sizes
  localparam int OPQ_DEPTH  = 4;
  localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  col;
    logic        row;
    logic [7:0]  ch;
    logic [15:0] number;
    logic [2:0]  digits;
  } in_req_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus_byte;
    logic       last;
  } out_res_t;

  typedef enum logic {
    OP_WRITE,
    OP_REFRESH
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CELL_W-1:0] addr;
    logic [7:0]        code;
  } op_t;

  typedef struct packed {
    logic [SCOL_W-1:0] col;
    logic              row;
  } scan_ptr_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_DIGIT
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_EMIT_CMD,
    BS_EMIT_DATA
  } back_state_t;

  // Step the scan pointer one cell, row-major, wrapping at the store end.
  function automatic scan_ptr_t advance_ptr(scan_ptr_t p);
    scan_ptr_t n;
    n = p;
    if (p.col >= SCOL_W'(COLUMNS - 1)) begin
      n.col = '0;
      if (p.row >= 1'(ROWS - 1)) begin
        n.row = 1'b0;
      end else begin
        n.row = 1'b1;
      end
    end else begin
      n.col = p.col + 1'b1;
    end
    return n;
  endfunction

  // Store index of a column and row.
  function automatic logic [CELL_W-1:0] cell_at(logic [4:0] c, logic r);
    return CELL_W'(r ? COLUMNS : 0) + CELL_W'(c);
  endfunction

  function automatic logic cell_ok(logic [4:0] c, logic r);
    return (int'(c) < COLUMNS) && (int'(r) < ROWS);
  endfunction

endpackage

// ===== src/char_display_dirty_refresh_unit.sv =====
// ----------------------------------------------------------------------------
// char_display_dirty_refresh_unit
// Character display buffer with per-cell dirty marks and incremental refresh.
// ----------------------------------------------------------------------------
// The unit keeps a ROWS x COLUMNS character store (reset to spaces) with one
// dirty mark per cell. A request is a character write, a number write (the
// low 2 to 5 decimal digits, leading zeros blanked, written rightward; cells
// past the last column are dropped) or a refresh tick. A refresh scans
// row-major from a wrapping pointer for the first dirty cell, emits a cursor
// command byte (rs 0) followed by the character (rs 1, last 1), clears the
// mark and steps the pointer one cell; a refresh that finds nothing emits no
// byte. Flow: a character write or refresh tick is accepted when no number
// write is in progress and the operation queue has room. A number write
// holds the request port through binary-to-decimal conversion and one digit
// write per digit, longer while the operation queue is full. On the store
// side a write is applied as it leaves the operation queue; a refresh leaves
// the operation queue, checks up to ROWS*COLUMNS cells (32 at the default
// size), one cell per cycle, then queues the byte pair (longer while the
// result queue is full); the request side keeps taking requests meanwhile
// until the four-entry operation queue fills. Results wait in a two-entry
// queue; a result left unpopped stalls the store side, then the request side.
module char_display_dirty_refresh_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  cddr_pkg::in_req_t  in_req,
  output logic               out_empty,
  input  logic               out_pop,
  output cddr_pkg::out_res_t out_res
);
  import cddr_pkg::*;

  logic op_push;
  op_t  op_data;
  logic op_full;
  logic op_pop;
  op_t  op_head;
  logic op_empty;

  // Front: take requests, expand numbers into per-cell writes.
  cddr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_req  (in_req),
    .op_push (op_push),
    .op_data (op_data),
    .op_full (op_full)
  );

  // Decouple the two sides so a long scan does not block new requests.
  cddr_opq u_opq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_data (op_data),
    .full      (op_full),
    .pop       (op_pop),
    .head      (op_head),
    .empty     (op_empty)
  );

  // Back: apply writes in order, run refresh scans, queue bus bytes.
  cddr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_empty  (op_empty),
    .op_head   (op_head),
    .op_pop    (op_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

endmodule

// ===== src/cddr_front.sv =====
// ----------------------------------------------------------------------------
// cddr_front
// Accepts requests, converts numbers to digits and issues cell operations.
// ----------------------------------------------------------------------------
module cddr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  cddr_pkg::in_req_t in_req,
  output logic             op_push,
  output cddr_pkg::op_t    op_data,
  input  logic             op_full
);
  import cddr_pkg::*;

  front_state_t state_r, state_nxt;

  logic [BIN_W-1:0]                bin_r;
  logic [BCD_DIGITS-1:0][3:0]      bcd_r;
  logic [BCD_DIGITS-1:0][3:0]      bcd_adj;
  logic [BCD_DIGITS-1:0][3:0]      bcd_nxt;
  logic [BIN_W-1:0]                bin_nxt;
  logic [BITCNT_W-1:0]             bit_cnt_r;
  logic [3:0]                      col_r;
  logic                            row_r;
  logic [2:0]                      count_r;
  logic [2:0]                      k_r;
  logic                            blank_r;

  logic       accept;
  logic [2:0] place;
  logic [3:0] digit;
  logic [7:0] digit_code;
  logic [4:0] col_sum;
  logic [2:0] count_clamp;
  logic       last_digit;

  assign in_full = (state_r != FS_IDLE) || op_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    if (in_req.digits < MIN_DIGITS) begin
      count_clamp = MIN_DIGITS;
    end else if (in_req.digits > MAX_DIGITS) begin
      count_clamp = MAX_DIGITS;
    end else begin
      count_clamp = in_req.digits;
    end
  end

  // One double-dabble step: adjust each digit, then shift in the next bit.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    {bcd_nxt, bin_nxt} = {bcd_adj, bin_r} << 1;
  end

  assign place      = count_r - 3'd1 - k_r;
  assign digit      = bcd_r[place];
  assign digit_code = (blank_r && (digit == 4'd0) && (place != 3'd0)) ?
                      SPACE_CODE : (ZERO_CODE + {4'd0, digit});
  assign col_sum    = {1'b0, col_r} + {2'd0, k_r};
  assign last_digit = (k_r == count_r - 3'd1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: begin
        if (accept && (in_req.func == FUNC_WRITE_NUM)) begin
          state_nxt = FS_CONV;
        end
      end
      FS_CONV: begin
        if (bit_cnt_r == BITCNT_W'(BIN_W - 1)) begin
          state_nxt = FS_DIGIT;
        end
      end
      FS_DIGIT: begin
        if (!op_full && last_digit) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  // Operation issue
  always_comb begin
    op_push      = 1'b0;
    op_data.kind = OP_WRITE;
    op_data.addr = cell_at({1'b0, in_req.col}, in_req.row);
    op_data.code = in_req.ch;
    unique case (state_r)
      FS_IDLE: begin
        if (accept && (in_req.func == FUNC_WRITE_CHAR)) begin
          op_push = cell_ok({1'b0, in_req.col}, in_req.row);
        end else if (accept && (in_req.func == FUNC_REFRESH)) begin
          op_push      = 1'b1;
          op_data.kind = OP_REFRESH;
        end
      end
      FS_DIGIT: begin
        op_data.addr = cell_at(col_sum, row_r);
        op_data.code = digit_code;
        // Drop digits that fall past the last column.
        op_push      = !op_full && cell_ok(col_sum, row_r);
      end
      default: op_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      FS_IDLE: begin
        if (accept) begin
          bin_r     <= in_req.number;
          bcd_r     <= '0;
          bit_cnt_r <= '0;
          col_r     <= in_req.col;
          row_r     <= in_req.row;
          count_r   <= count_clamp;
          k_r       <= '0;
          blank_r   <= 1'b1;
        end
      end
      FS_CONV: begin
        bin_r     <= bin_nxt;
        bcd_r     <= bcd_nxt;
        bit_cnt_r <= bit_cnt_r + 1'b1;
      end
      FS_DIGIT: begin
        if (!op_full) begin
          k_r <= k_r + 3'd1;
          if (digit_code != SPACE_CODE) begin
            blank_r <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/cddr_opq.sv =====
// ----------------------------------------------------------------------------
// cddr_opq
// Short queue of cell operations between the front and back parts.
// ----------------------------------------------------------------------------
module cddr_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cddr_pkg::op_t push_data,
  output logic          full,
  input  logic          pop,
  output cddr_pkg::op_t head,
  output logic          empty
);
  import cddr_pkg::*;

  op_t               slot_r [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_r;
  logic [OPQ_AW-1:0] rd_r;
  logic [OPQ_AW:0]   cnt_r;

  assign full  = (cnt_r == (OPQ_AW + 1)'(OPQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_r <= rd_r + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/cddr_back.sv =====
// ----------------------------------------------------------------------------
// cddr_back
// Holds the character store and dirty marks, runs the refresh scan and
// queues the cursor and data bytes.
// ----------------------------------------------------------------------------
module cddr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_empty,
  input  cddr_pkg::op_t      op_head,
  output logic               op_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output cddr_pkg::out_res_t out_res
);
  import cddr_pkg::*;

  back_state_t state_r, state_nxt;

  logic [7:0]           store_r [NUM_CELLS];
  logic [NUM_CELLS-1:0] dirty_r;
  scan_ptr_t            ptr_r;
  logic [CELL_W-1:0]    cnt_r;

  out_res_t           res_r [RESQ_DEPTH];
  logic [RESQ_AW-1:0] res_wr_r;
  logic [RESQ_AW-1:0] res_rd_r;
  logic [RESQ_AW:0]   res_cnt_r;

  logic              res_full;
  logic              res_push;
  out_res_t          res_data;
  logic [CELL_W-1:0] scan_cell;
  logic              hit;
  logic              scan_end;
  logic              res_take;

  assign scan_cell = CELL_W'(ptr_r.row ? COLUMNS : 0) + CELL_W'(ptr_r.col);
  assign hit       = dirty_r[scan_cell];
  assign scan_end  = (cnt_r == CELL_W'(NUM_CELLS - 1));
  assign res_full  = (res_cnt_r == (RESQ_AW + 1)'(RESQ_DEPTH));
  assign out_empty = (res_cnt_r == '0);
  assign out_res   = res_r[res_rd_r];
  assign res_take  = out_pop && !out_empty;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (!op_empty && (op_head.kind == OP_REFRESH)) begin
          state_nxt = BS_SCAN;
        end
      end
      BS_SCAN: begin
        if (hit) begin
          state_nxt = BS_EMIT_CMD;
        end else if (scan_end) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_EMIT_CMD: begin
        if (!res_full) begin
          state_nxt = BS_EMIT_DATA;
        end
      end
      BS_EMIT_DATA: begin
        if (!res_full) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    op_pop            = 1'b0;
    res_push          = 1'b0;
    res_data.rs       = 1'b0;
    res_data.bus_byte = CURSOR_CMD | (({8{ptr_r.row}} & ROW_OFFSET) + 8'(ptr_r.col));
    res_data.last     = 1'b0;
    unique case (state_r)
      BS_IDLE: begin
        op_pop = !op_empty;
      end
      BS_EMIT_CMD: begin
        res_push = !res_full;
      end
      BS_EMIT_DATA: begin
        res_push          = !res_full;
        res_data.rs       = 1'b1;
        res_data.bus_byte = store_r[scan_cell];
        res_data.last     = 1'b1;
      end
      default: res_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Store, dirty marks and scan pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        store_r[i] <= SPACE_CODE;
      end
      dirty_r <= '0;
      ptr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        BS_IDLE: begin
          cnt_r <= '0;
          if (op_pop && (op_head.kind == OP_WRITE)) begin
            store_r[op_head.addr] <= op_head.code;
            dirty_r[op_head.addr] <= 1'b1;
          end
        end
        BS_SCAN: begin
          if (!hit) begin
            cnt_r <= cnt_r + 1'b1;
            // A full lap found nothing: land one cell past the start.
            ptr_r <= scan_end ? advance_ptr(advance_ptr(ptr_r)) : advance_ptr(ptr_r);
          end
        end
        BS_EMIT_DATA: begin
          if (!res_full) begin
            dirty_r[scan_cell] <= 1'b0;
            ptr_r              <= advance_ptr(ptr_r);
          end
        end
        default: ;
      endcase
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r[res_wr_r] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (res_push) begin
        res_wr_r <= res_wr_r + 1'b1;
      end
      if (res_take) begin
        res_rd_r <= res_rd_r + 1'b1;
      end
      if (res_push && !res_take) begin
        res_cnt_r <= res_cnt_r + 1'b1;
      end else if (!res_push && res_take) begin
        res_cnt_r <= res_cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/cddr_chk.sv =====
// ----------------------------------------------------------------------------
// cddr_chk
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cddr_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input cddr_pkg::out_res_t out_res
);
  import cddr_pkg::*;

  // Hold a waiting result until it is popped.
  `ASSERT_CLK(a_res_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_res)), "result changed or vanished before pop")

  // A command byte is a cursor command and never closes a pair.
  `ASSERT_CLK(a_cmd_form, clk, rst_n, (!out_empty && !out_res.rs) |-> (out_res.bus_byte[7] && !out_res.last), "malformed cursor command")

  // A data byte always closes its pair.
  `ASSERT_CLK(a_data_last, clk, rst_n, (!out_empty && out_res.rs) |-> out_res.last, "data byte without last")

  // The data byte is ready right after its command byte leaves.
  `ASSERT_CLK(a_pair_follow, clk, rst_n, (!out_empty && out_pop && !out_res.rs) |=> (!out_empty && out_res.rs), "command byte not followed by data byte")

endmodule

bind char_display_dirty_refresh_unit cddr_chk u_chk (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Randomized request/result check of the dirty-cell display refresh unit.
// ----------------------------------------------------------------------------
// A clocked driver pushes requests from a queue that the stimulus block fills
// up front: a short directed part first, then random episodes of writes and
// refresh ticks. Each accepted request updates a shadow copy of the character
// store, dirty marks and scan pointer, and queues the byte pair a refresh is
// due to emit. A clocked monitor pops results with random stalls and compares
// each one, field by field, with the oldest queued byte.
// ----------------------------------------------------------------------------
module testbench;
  import cddr_pkg::*;

  // Function code with no meaning to the unit; it must be ignored.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 1300;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  in_req_t  in_req = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  out_res_t out_res;

  char_display_dirty_refresh_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow of the display state, updated once per accepted request
  // --------------------------------------------------------------------------
  logic [7:0]        shadow_chars [NUM_CELLS];
  logic              shadow_dirty [NUM_CELLS];
  logic [SCOL_W-1:0] shadow_scan_col;
  logic              shadow_scan_row;

  in_req_t  request_q [$];   // requests still to be pushed
  out_res_t display_bytes [$]; // bytes the unit owes, oldest first
  int       fail_count = 0;
  int       drive_calm = 0;
  int       pop_calm = 0;
  int       drive_wait = 0;
  int       pop_wait = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < NUM_CELLS; i++) begin
      shadow_chars[i] = SPACE_CODE;
      shadow_dirty[i] = 1'b0;
    end
    shadow_scan_col = '0;
    shadow_scan_row = 1'b0;
  endfunction

  // Store a code and mark the cell dirty; drop cells off the display.
  function automatic void mark_cell(int c, int r, logic [7:0] code);
    if (c < COLUMNS && r < ROWS) begin
      shadow_chars[r * COLUMNS + c] = code;
      shadow_dirty[r * COLUMNS + c] = 1'b1;
    end
  endfunction

  function automatic void bump_scan_ptr();
    if (int'(shadow_scan_col) >= COLUMNS - 1) begin
      shadow_scan_col = '0;
      shadow_scan_row = (int'(shadow_scan_row) >= ROWS - 1) ? 1'b0 : 1'b1;
    end else begin
      shadow_scan_col = shadow_scan_col + 1'b1;
    end
  endfunction

  function automatic int scan_index();
    return int'(shadow_scan_row) * COLUMNS + int'(shadow_scan_col);
  endfunction

  // Apply one accepted request and queue the bytes it must produce.
  function automatic void apply_display_request(in_req_t req);
    int count;
    int place;
    int scale;
    int digit;
    int scanned;
    bit blanking;
    logic [7:0] code;
    out_res_t pair;
    case (req.func)
      FUNC_WRITE_CHAR: begin
        mark_cell(int'(req.col), int'(req.row), req.ch);
      end
      FUNC_WRITE_NUM: begin
        count = int'(req.digits);
        if (count < 2) count = 2;
        if (count > 5) count = 5;
        blanking = 1'b1;
        for (int k = 0; k < count; k++) begin
          place = count - 1 - k;
          scale = 1;
          for (int p = 0; p < place; p++) scale = scale * 10;
          digit = (int'(req.number) / scale) % 10;
          // Blank leading zeros, but always show the units digit.
          if (blanking && digit == 0 && place != 0) begin
            code = SPACE_CODE;
          end else begin
            blanking = 1'b0;
            code = ZERO_CODE + 8'(digit);
          end
          mark_cell(int'(req.col) + k, int'(req.row), code);
        end
      end
      FUNC_REFRESH: begin
        scanned = 0;
        while (!shadow_dirty[scan_index()] && scanned < NUM_CELLS) begin
          bump_scan_ptr();
          scanned++;
        end
        if (shadow_dirty[scan_index()]) begin
          pair.rs = 1'b0;
          pair.bus_byte = CURSOR_CMD | (8'(shadow_scan_row) * ROW_OFFSET
                                        + 8'(shadow_scan_col));
          pair.last = 1'b0;
          display_bytes.push_back(pair);
          pair.rs = 1'b1;
          pair.bus_byte = shadow_chars[scan_index()];
          pair.last = 1'b1;
          display_bytes.push_back(pair);
          shadow_dirty[scan_index()] = 1'b0;
        end
        bump_scan_ptr();
      end
      default: begin
      end
    endcase
  endfunction

  // Wait length for one handshake; now and then run a stretch with no waits.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic in_req_t make_request(logic [1:0] func, int c, int r,
                                           int code, int value, int count);
    in_req_t req;
    req.func = func;
    req.col = 4'(c);
    req.row = 1'(r);
    req.ch = 8'(code);
    req.number = 16'(value);
    req.digits = 3'(count);
    return req;
  endfunction

  function automatic in_req_t random_request(logic [1:0] func);
    in_req_t req;
    int value;
    int count;
    case ($urandom_range(0, 2))
      0: value = $urandom_range(0, 65535);
      1: value = $urandom_range(0, 99);
      default: value = $urandom_range(0, 9999);
    endcase
    // Mostly legal digit counts, sometimes the clamped ones.
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 5);
    req = make_request(func, $urandom_range(0, 15), $urandom_range(0, 1),
                       $urandom_range(0, 255), value, count);
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hold a request until accepted, then wait a drawn number of cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_req <= '0;
      drive_wait <= 0;
    end else if (!(in_push && in_full)) begin
      if (in_push) begin
        apply_display_request(in_req);
        gap = draw_wait(drive_calm);
      end else begin
        gap = drive_wait;
      end
      if (gap > 0) begin
        in_push <= 1'b0;
        drive_wait <= gap - 1;
      end else if (request_q.size() > 0) begin
        in_req <= request_q.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pop results with random stalls and check each field
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int stall;
    out_res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_wait <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (display_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result rs=%0b byte=%02h last=%0b",
                     $realtime, out_res.rs, out_res.bus_byte, out_res.last);
        end else begin
          want = display_bytes.pop_front();
          if (out_res.rs !== want.rs || out_res.bus_byte !== want.bus_byte ||
              out_res.last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch expected rs=%0b byte=%02h last=%0b, got rs=%0b byte=%02h last=%0b",
                       $realtime, want.rs, want.bus_byte, want.last,
                       out_res.rs, out_res.bus_byte, out_res.last);
          end
        end
        stall = draw_wait(pop_calm);
      end else begin
        stall = pop_wait;
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        pop_wait <= stall - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: fill the request queue, then run to the end
  // --------------------------------------------------------------------------
  initial begin
    int made;
    int n_writes;
    int n_ticks;
    clear_shadow();

    // Refresh with nothing dirty: no bytes, pointer moves one cell.
    request_q.push_back(make_request(FUNC_REFRESH, 0, 0, 0, 0, 0));
    // Unused code with every field at its top: must change nothing.
    request_q.push_back(make_request(FUNC_UNUSED, 15, 1, 255, 65535, 7));
    request_q.push_back(make_request(FUNC_REFRESH, 15, 1, 255, 65535, 7));
    // Character writes at the corners with the extreme codes.
    request_q.push_back(make_request(FUNC_WRITE_CHAR, 0, 0, 8'h00, 0, 0));
    request_q.push_back(make_request(FUNC_WRITE_CHAR, 15, 1, 8'hFF, 65535, 7));
    request_q.push_back(make_request(FUNC_REFRESH, 0, 0, 0, 0, 0));
    request_q.push_back(make_request(FUNC_REFRESH, 0, 0, 0, 0, 0));
    // Zero shows as a blank then the units digit.
    request_q.push_back(make_request(FUNC_WRITE_NUM, 0, 0, 0, 0, 2));
    // Largest value in five digits on the bottom row.
    request_q.push_back(make_request(FUNC_WRITE_NUM, 11, 1, 0, 65535, 5));
    // Digit count too high acts as five; digits past the edge drop.
    request_q.push_back(make_request(FUNC_WRITE_NUM, 14, 0, 0, 12345, 7));
    // Digit count too low acts as two, second digit off the edge.
    request_q.push_back(make_request(FUNC_WRITE_NUM, 15, 1, 0, 7, 0));
    request_q.push_back(make_request(FUNC_WRITE_NUM, 4, 0, 0, 5, 1));
    // Inner zeros stay zeros once a digit has shown.
    request_q.push_back(make_request(FUNC_WRITE_NUM, 6, 1, 0, 100, 5));
    request_q.push_back(make_request(FUNC_WRITE_NUM, 2, 1, 0, 99999 % 65536, 6));
    repeat (11) request_q.push_back(make_request(FUNC_REFRESH, 0, 0, 0, 0, 0));

    // Random episodes: a few writes, then refresh ticks to drain them.
    made = 0;
    while (made < RANDOM_REQS) begin
      n_writes = $urandom_range(0, 4);
      n_ticks = $urandom_range(0, 6);
      for (int i = 0; i < n_writes; i++) begin
        request_q.push_back(random_request(($urandom_range(0, 4) < 3) ?
                                           FUNC_WRITE_CHAR : FUNC_WRITE_NUM));
        made++;
      end
      for (int i = 0; i < n_ticks; i++) begin
        request_q.push_back(random_request(FUNC_REFRESH));
        made++;
      end
      // Sprinkle an ignored request now and then.
      if ($urandom_range(0, 9) == 0)
        request_q.push_back(random_request(FUNC_UNUSED));
    end
    // Drain any marks still set at the end.
    repeat (NUM_CELLS + 2) request_q.push_back(random_request(FUNC_REFRESH));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Sample away from the active edge so the driver's queue is settled.
    @(negedge clk);
    while (request_q.size() != 0 || in_push || display_bytes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (display_bytes.size() != 0) begin
      fail_count++;
      $display("%0d expected bytes never arrived", display_bytes.size());
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== char_display_dirty_refresh_unit.f =====
+incdir+src
src/cddr_pkg.sv
src/cddr_front.sv
src/cddr_opq.sv
src/cddr_back.sv
src/char_display_dirty_refresh_unit.sv
src/cddr_chk.sv
test/testbench.sv
